// ===== rtl/core/sorted_list_insert_delete_unit_defines.svh =====
// Assertion macros for the sorted list insert and delete unit.
`ifndef SORTED_LIST_INSERT_DELETE_UNIT_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that an expression holds on every clock edge out of reset.
`define SLID_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sorted list check failed");

// Check that a condition leads to a consequence in the next cycle.
`define SLID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list check failed");

`else

`define SLID_ASSERT_ALWAYS(label, expr)
`define SLID_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/slid_pkg.sv =====
// Package with types, codes and sizes shared by the sorted list unit.
`timescale 1ns / 1ps

package slid_pkg;

    // Default list capacity
    localparam int SLID_DEPTH = 16;

    // Field widths
    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Stream word widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Command codes
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

    // Broadcast command to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } slid_cmd_t;

    // Compare flags a cell hands to its upper neighbour and to the control
    typedef struct packed {
        logic ge;
        logic eq;
    } slid_flag_t;

endpackage

// ===== rtl/core/slid_cell.sv =====
// One cell of the list: holds one entry, compares it and shifts with its neighbours.
`timescale 1ns / 1ps

module slid_cell #(
    parameter int DEPTH = slid_pkg::SLID_DEPTH,
    parameter int IDX   = 0
) (
    input  logic                                clk,
    input  logic [$clog2(DEPTH+1)-1:0]          occ,
    input  slid_pkg::slid_cmd_t                 cmd,
    input  logic [slid_pkg::VALUE_W-1:0]        value,
    input  logic [slid_pkg::VALUE_W-1:0]        left_entry,
    input  slid_pkg::slid_flag_t                left_flag,
    input  logic [slid_pkg::VALUE_W-1:0]        right_entry,
    output logic [slid_pkg::VALUE_W-1:0]        entry,
    output slid_pkg::slid_flag_t                flag
);
    import slid_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;
    logic               valid;
    logic               at_count;

    // Cell holds live data when its position lies below the occupancy
    assign valid    = occ > CW'(IDX);
    assign at_count = occ == CW'(IDX);

    // Compare the held entry with the operand
    assign flag.ge = valid && ($signed(entry_reg) >= $signed(value));
    assign flag.eq = valid && (entry_reg == value);
    assign entry   = entry_reg;

    // Choose the new entry: shift right on insert, shift left on delete
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (left_flag.ge)
                entry_next = left_entry;
            else if (flag.ge || at_count)
                entry_next = value;
        end
        else if (cmd.del)
        begin
            if (flag.ge)
                entry_next = right_entry;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/core/sorted_list_insert_delete_unit.sv =====
// Sorted list unit: a row of compare-and-shift cells with stream ports.
// Usage:
//   Commands arrive on the slave stream. s_tuser carries the opcode
//   (insert, delete, read); s_tdata carries the operand value and the read
//   index. Each accepted word yields exactly one result word on the master
//   stream: m_tuser carries the status, m_tdata the value read and the
//   count of entries held after the command.
//   All cells compare the operand at once and shift by one place with
//   their neighbour, so a result appears on the master side the cycle
//   after the command is accepted. One command per cycle is sustained
//   while the receiver takes results.
//   The result sits in an output register; a new command is accepted in
//   the same cycle as the held result is taken. When the receiver stalls,
//   the result holds and s_tready drops until it is taken.
//   Reset empties the list (occupancy zero) and clears the output valid;
//   no clearing pass is needed, cells above the occupancy are ignored.
//   An insert into a full list and a delete of an absent value leave the
//   list unchanged and report their status.
`timescale 1ns / 1ps
`include "sorted_list_insert_delete_unit_defines.svh"

module sorted_list_insert_delete_unit #(
    parameter int DEPTH = slid_pkg::SLID_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] value, [35:32] index, [39:36] zero
    input  logic [slid_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] opcode
    input  logic [slid_pkg::OPCODE_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] read_value, [36:32] count, [39:37] zero
    output logic [slid_pkg::M_TDATA_W-1:0]     m_tdata,
    // [1:0] status
    output logic [slid_pkg::STATUS_W-1:0]      m_tuser
);
    import slid_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int XW   = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int RD_N = (DEPTH < (1 << INDEX_W)) ? DEPTH : (1 << INDEX_W);

    logic [VALUE_W-1:0]  cell_entry [DEPTH];
    slid_flag_t          cell_flag  [DEPTH];
    slid_cmd_t           cmd;

    logic [CW-1:0]       occ_reg;
    logic [CW-1:0]       occ_next;
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [VALUE_W-1:0]  rd_reg;
    logic [VALUE_W-1:0]  rd_next;
    logic [COUNT_W-1:0]  count_reg;

    logic                accept;
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  value;
    logic [INDEX_W-1:0]  index;
    logic                full;
    logic                found;
    logic                index_ok;
    logic [VALUE_W-1:0]  rd_sel;

    // Unpack the command word
    assign opcode = s_tuser;
    assign value  = s_tdata[VALUE_W-1:0];
    assign index  = s_tdata[VALUE_W +: INDEX_W];

    // Take a new word whenever the output register is free or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign full     = occ_reg == CW'(DEPTH);
    assign index_ok = XW'(index) < XW'(occ_reg);

    // Gather equality flags for the delete
    always_comb
    begin
        found = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            found = found | cell_flag[i].eq;
    end

    // Select the entry at the read index
    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < RD_N; i++)
            if (index == INDEX_W'(i))
                rd_sel = rd_sel | cell_entry[i];
    end

    // Drive the cells only for commands that change the list
    assign cmd.ins = accept && (opcode == OP_INSERT) && !full;
    assign cmd.del = accept && (opcode == OP_DELETE) && found;

    // Row of cells
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [VALUE_W-1:0] left_entry;
        slid_flag_t         left_flag;
        logic [VALUE_W-1:0] right_entry;

        if (g == 0)
        begin : g_first
            assign left_entry = '0;
            assign left_flag  = '0;
        end
        else
        begin : g_inner
            assign left_entry = cell_entry[g-1];
            assign left_flag  = cell_flag[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_entry = cell_entry[g];
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[g+1];
        end

        slid_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .clk         (clk),
            .occ         (occ_reg),
            .cmd         (cmd),
            .value       (value),
            .left_entry  (left_entry),
            .left_flag   (left_flag),
            .right_entry (right_entry),
            .entry       (cell_entry[g]),
            .flag        (cell_flag[g])
        );
    end

    // Work out status, read data and new occupancy
    always_comb
    begin
        status_next = ST_OK;
        rd_next     = '0;
        occ_next    = occ_reg;
        unique case (opcode)
            OP_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    occ_next = occ_reg + CW'(1);
            end
            OP_DELETE:
            begin
                if (found)
                    occ_next = occ_reg - CW'(1);
                else
                    status_next = ST_NOT_FOUND;
            end
            OP_READ:
            begin
                if (index_ok)
                    rd_next = rd_sel;
                else
                    status_next = ST_BAD_INDEX;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Hold occupancy and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                occ_reg      <= occ_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            rd_reg     <= rd_next;
            count_reg  <= COUNT_W'(occ_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - COUNT_W){1'b0}}, count_reg, rd_reg};

    // Checks
    `SLID_ASSERT_ALWAYS(a_occ_bound, occ_reg <= CW'(DEPTH))
    `SLID_ASSERT_NEXT(a_full_refused, accept && (opcode == OP_INSERT) && full,
        (m_tuser == ST_FULL) && (occ_reg == CW'(DEPTH)))
    `SLID_ASSERT_NEXT(a_insert_grows, cmd.ins, occ_reg == $past(occ_reg) + CW'(1))

endmodule
